// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every clock edge out of reset
`define HRBT_ASSERT(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// same-cycle implication
`define HRBT_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HRBT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/hrbt_pkg.sv =====
`default_nettype none

package hrbt_pkg;

   localparam logic [4:0] KIND_ID         = 5'd0;
   localparam logic [4:0] KIND_CRLF       = 5'd1;
   localparam logic [4:0] KIND_SPACE      = 5'd2;
   localparam logic [4:0] KIND_PUNCT_BASE = 5'd3;
   localparam logic [4:0] KIND_UNKNOWN    = 5'd21;

   localparam int PUNCT_COUNT = 17;
   localparam logic [7:0] PUNCT_MARKS [PUNCT_COUNT] = '{
      8'h21, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B, 8'h2C,
      8'h3B, 8'h3D, 8'h25, 8'h3A, 8'h40, 8'h3F, 8'h2F, 8'h2E
   };

   localparam int TOKEN_FIFO_DEPTH = 4;
   localparam int TOKEN_FIFO_AW    = $clog2(TOKEN_FIFO_DEPTH);

   typedef logic [TOKEN_FIFO_AW-1:0] fifo_ptr_type;
   typedef logic [TOKEN_FIFO_AW:0]   fifo_level_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_request;
   } req_beat_type;

   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] token_start;
      logic [15:0] token_length;
      logic        request_done;
      logic        run_last;
   } rsp_beat_type;

   typedef struct packed {
      logic in_identifier;
      logic cr_pending;
   } scan_flags_type;

   typedef struct packed {
      fifo_level_type level;
      logic           has_room;
   } fifo_status_type;

endpackage

`default_nettype wire

// ===== rtl/hrbt_classify.sv =====
`default_nettype none

module hrbt_classify #(
   parameter int unsigned POSITION_WIDTH = 16
) (
   input  hrbt_pkg::req_beat_type        beat,
   input  hrbt_pkg::scan_flags_type      flags,
   input  logic [POSITION_WIDTH-1:0]     position,
   input  logic [POSITION_WIDTH-1:0]     id_start,
   input  logic [15:0]                   id_length,
   output hrbt_pkg::scan_flags_type      next_flags,
   output logic [POSITION_WIDTH-1:0]     next_position,
   output logic [POSITION_WIDTH-1:0]     next_id_start,
   output logic [15:0]                   next_id_length,
   output hrbt_pkg::rsp_beat_type [1:0]  tokens,
   output logic [1:0]                    token_count
);
   import hrbt_pkg::*;

   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_UNDER = 8'h5F;
   localparam int ExtWidth = POSITION_WIDTH + 16;

   function automatic logic is_letter(input logic [7:0] b);
      return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) || b == CHAR_UNDER;
   endfunction

   function automatic logic is_ident_char(input logic [7:0] b);
      return is_letter(b) || (b >= 8'h30 && b <= 8'h39);
   endfunction

   function automatic logic [4:0] punct_kind(input logic [7:0] b);
      logic [4:0] kind;
      kind = KIND_UNKNOWN;
      for (int i = 0; i < PUNCT_COUNT; i++) begin
         if (b == PUNCT_MARKS[i]) begin
            kind = 5'(KIND_PUNCT_BASE + 5'(i));
         end
      end
      return kind;
   endfunction

   function automatic logic [15:0] start16(input logic [POSITION_WIDTH-1:0] v);
      logic [ExtWidth-1:0] ext;
      ext = ExtWidth'(v);
      return ext[15:0];
   endfunction

   function automatic rsp_beat_type make_token(input logic [4:0] kind,
                                               input logic [15:0] start,
                                               input logic [15:0] len);
      rsp_beat_type t;
      t = '0;
      t.token_kind   = kind;
      t.token_start  = start;
      t.token_length = len;
      return t;
   endfunction

   logic [7:0]                b;
   logic                      last;
   logic                      consumed;
   logic                      nid;
   logic                      ncr;
   logic [POSITION_WIDTH-1:0] nstart;
   logic [15:0]               nlen;
   logic [POSITION_WIDTH-1:0] cr_at;
   logic [1:0]                n;
   logic                      last_idx;

   assign b     = beat.data_byte;
   assign last  = beat.end_of_request;
   assign cr_at = position - POSITION_WIDTH'(1);

   always_comb begin
      tokens   = '0;
      n        = 2'd0;
      consumed = 1'b0;
      nid      = flags.in_identifier;
      ncr      = 1'b0;
      nstart   = id_start;
      nlen     = id_length;
      last_idx = 1'b0;

      // pending cr resolves against this byte
      if (flags.cr_pending) begin
         if (b == CHAR_LF) begin
            tokens[n[0]] = make_token(KIND_CRLF, start16(cr_at), 16'd2);
            consumed = 1'b1;
         end else begin
            tokens[n[0]] = make_token(KIND_UNKNOWN, start16(cr_at), 16'd1);
         end
         n = n + 2'd1;
      end

      if (!consumed && flags.in_identifier) begin
         if (is_ident_char(b)) begin
            if (id_length != 16'hFFFF) begin
               nlen = id_length + 16'd1;
            end
            consumed = 1'b1;
         end else begin
            tokens[n[0]] = make_token(KIND_ID, start16(id_start), id_length);
            n = n + 2'd1;
            nid = 1'b0;
         end
      end

      if (!consumed) begin
         priority if (is_letter(b)) begin
            nid    = 1'b1;
            nstart = position;
            nlen   = 16'd1;
         end else if (b == CHAR_CR) begin
            ncr = 1'b1;
         end else if (b == CHAR_SPACE) begin
            tokens[n[0]] = make_token(KIND_SPACE, start16(position), 16'd1);
            n = n + 2'd1;
         end else begin
            tokens[n[0]] = make_token(punct_kind(b), start16(position), 16'd1);
            n = n + 2'd1;
         end
      end

      // flush at end of request
      if (last) begin
         if (nid) begin
            tokens[n[0]] = make_token(KIND_ID, start16(nstart), nlen);
            n = n + 2'd1;
         end
         if (ncr) begin
            tokens[n[0]] = make_token(KIND_UNKNOWN, start16(position), 16'd1);
            n = n + 2'd1;
         end
      end

      if (n != 2'd0) begin
         last_idx = n[1];
         tokens[last_idx].run_last     = 1'b1;
         tokens[last_idx].request_done = last;
      end

      token_count = n;

      if (last) begin
         next_flags     = '0;
         next_position  = '0;
         next_id_start  = '0;
         next_id_length = '0;
      end else begin
         next_flags.in_identifier = nid;
         next_flags.cr_pending    = ncr;
         next_position  = position + POSITION_WIDTH'(1);
         next_id_start  = nstart;
         next_id_length = nlen;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/hrbt_fifo.sv =====
`default_nettype none

module hrbt_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  hrbt_pkg::rsp_beat_type [1:0]  tokens,
   input  logic [1:0]                    token_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output hrbt_pkg::rsp_beat_type        rsp_beat,
   output hrbt_pkg::fifo_status_type     status
);
   import hrbt_pkg::*;

   rsp_beat_type   entry_ff [TOKEN_FIFO_DEPTH];
   fifo_ptr_type   wr_ptr_ff;
   fifo_ptr_type   wr_ptr_in;
   fifo_ptr_type   rd_ptr_ff;
   fifo_ptr_type   rd_ptr_in;
   fifo_level_type level_ff;
   fifo_level_type level_in;
   logic [1:0]     push_n;
   logic           pop;
   fifo_ptr_type   wr_ptr_next;

   assign push_n      = push ? token_count : 2'd0;
   assign pop         = rsp_valid && !rsp_stall;
   assign wr_ptr_next = wr_ptr_ff + fifo_ptr_type'(1);

   assign wr_ptr_in = wr_ptr_ff + fifo_ptr_type'(push_n);
   assign rd_ptr_in = rd_ptr_ff + fifo_ptr_type'(pop);
   assign level_in  = level_ff + fifo_level_type'(push_n) - fifo_level_type'(pop);

   assign rsp_valid       = level_ff != '0;
   assign rsp_beat        = entry_ff[rd_ptr_ff];
   assign status.level    = level_ff;
   assign status.has_room = level_ff <= fifo_level_type'(TOKEN_FIFO_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         entry_ff[wr_ptr_ff] <= tokens[0];
      end
      if (push_n == 2'd2) begin
         entry_ff[wr_ptr_next] <= tokens[1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/http_request_byte_tokenizer_top.sv =====
`default_nettype none

`include "assert_macros.svh"

// Byte-stream tokenizer for HTTP requests. One request byte is taken per beat
// and every byte is classified in the cycle it is accepted; its tokens (none,
// one or two) land in a four-entry token queue and appear on the rsp channel
// from the next cycle on, one token per beat. The input takes a byte every
// cycle while the queue holds two tokens or fewer, so the rate is one byte per
// clock as long as the bytes produce no more tokens than the output drains;
// a byte that closes one token and emits another costs a second output beat,
// and the queue depth sets how many such bytes can come in a row before
// req_stall rises. State returns to offset zero after the byte flagged as the
// end of the request, which flushes any open identifier or lone carriage return.
module http_request_byte_tokenizer_top #(
   parameter int unsigned POSITION_WIDTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  hrbt_pkg::req_beat_type  req_beat,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output hrbt_pkg::rsp_beat_type  rsp_beat
);
   import hrbt_pkg::*;

   scan_flags_type            flags_ff;
   scan_flags_type            flags_in;
   logic [POSITION_WIDTH-1:0] byte_position_ff;
   logic [POSITION_WIDTH-1:0] byte_position_in;
   logic [POSITION_WIDTH-1:0] id_start_ff;
   logic [POSITION_WIDTH-1:0] id_start_in;
   logic [15:0]               id_length_ff;
   logic [15:0]               id_length_in;
   rsp_beat_type [1:0]        tokens;
   logic [1:0]                token_count;
   fifo_status_type           fifo_status;
   logic                      accept;

   assign req_stall = !fifo_status.has_room;
   assign accept    = req_valid && !req_stall;

   hrbt_classify #(
      .POSITION_WIDTH(POSITION_WIDTH)
   ) u_classify (
      .beat           (req_beat),
      .flags          (flags_ff),
      .position       (byte_position_ff),
      .id_start       (id_start_ff),
      .id_length      (id_length_ff),
      .next_flags     (flags_in),
      .next_position  (byte_position_in),
      .next_id_start  (id_start_in),
      .next_id_length (id_length_in),
      .tokens         (tokens),
      .token_count    (token_count)
   );

   hrbt_fifo u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (accept),
      .tokens      (tokens),
      .token_count (token_count),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_beat    (rsp_beat),
      .status      (fifo_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff         <= '0;
         byte_position_ff <= '0;
         id_start_ff      <= '0;
         id_length_ff     <= '0;
      end else if (accept) begin
         flags_ff         <= flags_in;
         byte_position_ff <= byte_position_in;
         id_start_ff      <= id_start_in;
         id_length_ff     <= id_length_in;
      end
   end

   `HRBT_ASSERT(a_queue_bound, fifo_status.level <= fifo_level_type'(TOKEN_FIFO_DEPTH), "token queue overflow")
   `HRBT_ASSERT(a_flags_exclusive, !(flags_ff.in_identifier && flags_ff.cr_pending), "identifier and cr pending together")
   `HRBT_ASSERT_NEXT(a_end_clears, accept && req_beat.end_of_request, byte_position_ff == '0 && flags_ff == '0, "state not cleared after end of request")
   `HRBT_ASSERT_IMPL(a_done_is_run_last, rsp_valid && rsp_beat.request_done, rsp_beat.run_last, "request_done without run_last")

endmodule

`default_nettype wire
